// ----- rtl/core/kfi_pkg.sv -----
// Shared types and constants for the keyframe interpolator.
package kfi_pkg;

  // Field widths fixed by the interface
  localparam int TIME_W = 32;
  localparam int VAL_W  = 32;
  localparam int KI_W   = 6;
  localparam int KC_W   = 7;
  localparam int SEG_W  = 6;

  // Defaults for the top-level parameters
  localparam int MAX_KEYS_DEF   = 64;
  localparam int ALPHA_BITS_DEF = 16;

  // Configuration register indexes
  localparam logic CFG_INTERP_MODE = 1'b0;
  localparam logic CFG_KEY_COUNT   = 1'b1;
  localparam int   CFG_IDX_W       = 1;
  localparam int   CFG_DATA_W      = KC_W;

  // Configuration reset values
  localparam logic            INTERP_MODE_RST = 1'b1;
  localparam logic [KC_W-1:0] KEY_COUNT_RST   = KC_W'(2);

  // Interpolation modes
  localparam logic MODE_STEP   = 1'b0;
  localparam logic MODE_LINEAR = 1'b1;

  // Input actions
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  typedef struct packed {
    logic                     action;
    logic [KI_W-1:0]          key_index;
    logic [TIME_W-1:0]        key_time;
    logic signed [VAL_W-1:0]  key_x;
    logic signed [VAL_W-1:0]  key_y;
    logic signed [VAL_W-1:0]  key_z;
    logic [TIME_W-1:0]        query_time;
  } kfi_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  out_x;
    logic signed [VAL_W-1:0]  out_y;
    logic signed [VAL_W-1:0]  out_z;
    logic [SEG_W-1:0]         segment_start;
  } kfi_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T0,
    ST_T1,
    ST_SEARCH,
    ST_SETUP,
    ST_DIV,
    ST_FETCH,
    ST_LOAD0,
    ST_LOAD1,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } kfi_state_t;

endpackage

// ----- rtl/core/keyframe_interpolator.sv -----
// Keyframe interpolator top level: key table, segment search, alpha divider and blend.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one transaction per item. An item
//   with action = write stores key_time and key_x/y/z at slot key_index in the same
//   cycle it is accepted; it produces no result. An item with action = sample clamps
//   query_time to the key range, finds the segment, and returns one result on the
//   output channel (out_valid/out_ready/out_data).
//   Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
//   index 0 is interp_mode (0 step, 1 linear), index 1 is key_count. Write it only
//   while no sample is in flight.
//   From acceptance to out_valid a sample passes through two clamp reads, a walk of
//   one key time per cycle through the single time-table read port, one quotient
//   bit per cycle in the restoring divider (skipped when alpha is 0 or 1), then, in
//   linear mode, three blends through one shared multiplier; step mode picks one
//   whole key instead.
//   The block takes no new item while a sample is in progress. A finished result sits
//   in the output register; the next item is accepted meanwhile, and a following
//   sample waits at its end until the output register is free.
//   Reset (rst_n low, synchronous) returns to idle, drops any pending result and sets
//   interp_mode to linear and key_count to 2. Key tables are not cleared.
module keyframe_interpolator #(
  parameter int MAX_KEYS   = kfi_pkg::MAX_KEYS_DEF,
  parameter int ALPHA_BITS = kfi_pkg::ALPHA_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  kfi_pkg::kfi_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output kfi_pkg::kfi_out_t                  out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [kfi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kfi_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import kfi_pkg::*;

  localparam int AW    = $clog2(MAX_KEYS);
  localparam int EXT_W = KI_W + AW + KC_W;
  localparam int ALW   = ALPHA_BITS + 1;
  localparam int PW    = VAL_W + 1 + ALW;
  localparam int CNT_W = $clog2(ALPHA_BITS + 1);
  localparam logic [ALW-1:0] ALPHA_ONE  = ALW'(1) << ALPHA_BITS;
  localparam logic [ALW-1:0] ALPHA_HALF = ALW'(1) << (ALPHA_BITS - 1);

  kfi_state_t state_r, state_nxt;

  // Configuration registers
  logic            mode_r;
  logic [KC_W-1:0] key_count_r;

  // Sequencer datapath registers
  logic [TIME_W-1:0]  q_r;
  logic [TIME_W-1:0]  prev_r;
  logic [TIME_W-1:0]  ta_r;
  logic [TIME_W-1:0]  tb_r;
  logic [AW-1:0]      last_r;
  logic [AW-1:0]      i_r;
  logic [AW-1:0]      b_r;
  logic [TIME_W-1:0]  rem_r;
  logic [TIME_W-1:0]  den_r;
  logic [ALW-1:0]     alpha_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [3*VAL_W-1:0] v0_r;
  logic [3*VAL_W-1:0] v1_r;
  logic [1:0]         comp_r;
  logic [PW-1:0]      prod_r;
  logic [VAL_W-1:0]   res_x_r, res_y_r, res_z_r;
  logic               out_valid_r;
  kfi_out_t           out_r;

  // RAM ports
  logic               key_we;
  logic [AW-1:0]      key_waddr;
  logic [AW-1:0]      t_raddr, v_raddr;
  logic [TIME_W-1:0]  t_rdata;
  logic [3*VAL_W-1:0] v_rdata;

  // Misc combinational
  logic               in_acc;
  logic [EXT_W-1:0]   idx_ext;
  logic [EXT_W-1:0]   kc_ext;
  logic [EXT_W-1:0]   n_ext;
  logic               alpha_zero, alpha_one;
  logic               search_hit;
  logic [TIME_W:0]    div_r2;
  logic               div_ge;
  logic [VAL_W-1:0]   comp_v0, comp_v1;
  logic [VAL_W:0]     comp_diff;
  logic signed [PW-1:0] mul_a, mul_b;
  logic [PW-1:0]      prod_shift;
  logic [VAL_W-1:0]   blend_res;
  logic               out_free;

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Map the key index into the table and drop writes beyond it
  assign idx_ext   = EXT_W'(in_data.key_index);
  assign key_waddr = idx_ext[AW-1:0];
  assign key_we    = in_acc && (in_data.action == ACT_WRITE) && (idx_ext < EXT_W'(MAX_KEYS));

  // Clamp the key count to between 2 and the table size
  assign kc_ext = EXT_W'(key_count_r);
  always_comb begin
    priority if (kc_ext < EXT_W'(2)) begin
      n_ext = EXT_W'(2);
    end else if (kc_ext > EXT_W'(MAX_KEYS)) begin
      n_ext = EXT_W'(MAX_KEYS);
    end else begin
      n_ext = kc_ext;
    end
  end

  // Segment and alpha decisions
  assign search_hit = (t_rdata >= q_r) || (i_r == last_r);
  assign alpha_zero = (ta_r <= tb_r) || (q_r <= tb_r);
  assign alpha_one  = (q_r >= ta_r);

  // Restoring divider step
  assign div_r2 = {rem_r, 1'b0};
  assign div_ge = div_r2 >= {1'b0, den_r};

  // Blend operands for the current component
  always_comb begin
    unique case (comp_r)
      2'd0: begin
        comp_v0 = v0_r[3*VAL_W-1:2*VAL_W];
        comp_v1 = v1_r[3*VAL_W-1:2*VAL_W];
      end
      2'd1: begin
        comp_v0 = v0_r[2*VAL_W-1:VAL_W];
        comp_v1 = v1_r[2*VAL_W-1:VAL_W];
      end
      default: begin
        comp_v0 = v0_r[VAL_W-1:0];
        comp_v1 = v1_r[VAL_W-1:0];
      end
    endcase
  end
  assign comp_diff  = {comp_v1[VAL_W-1], comp_v1} - {comp_v0[VAL_W-1], comp_v0};
  // Sign-extend both multiplier operands to the full product width
  assign mul_a      = PW'($signed(comp_diff));
  assign mul_b      = PW'($signed({1'b0, alpha_r}));
  assign prod_shift = $signed(prod_r) >>> ALPHA_BITS;
  assign blend_res  = comp_v0 + prod_shift[VAL_W-1:0];

  // Key tables
  kfi_ram #(
    .WIDTH(TIME_W),
    .DEPTH(MAX_KEYS)
  ) u_time_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (in_data.key_time),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  kfi_ram #(
    .WIDTH(3 * VAL_W),
    .DEPTH(MAX_KEYS)
  ) u_value_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata ({in_data.key_x, in_data.key_y, in_data.key_z}),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_data.action == ACT_SAMPLE)) begin
          state_nxt = ST_T0;
        end
      end
      ST_T0:     state_nxt = ST_T1;
      ST_T1:     state_nxt = ST_SEARCH;
      ST_SEARCH: begin
        if (search_hit) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (alpha_zero || alpha_one) begin
          state_nxt = ST_FETCH;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: state_nxt = ST_LOAD0;
      ST_LOAD0: state_nxt = ST_LOAD1;
      ST_LOAD1: begin
        if (mode_r == MODE_STEP) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: state_nxt = ST_ADD;
      ST_ADD: begin
        if (comp_r == 2'd2) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and read addresses
  always_comb begin
    in_ready = 1'b0;
    t_raddr  = '0;
    v_raddr  = b_r;
    unique case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_T0:     t_raddr  = last_r;
      ST_T1:     t_raddr  = AW'(1);
      ST_SEARCH: t_raddr  = i_r + AW'(1);
      ST_LOAD0:  v_raddr  = b_r + AW'(1);
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= INTERP_MODE_RST;
      key_count_r <= KEY_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_INTERP_MODE: mode_r      <= cfg_data[0];
        CFG_KEY_COUNT:   key_count_r <= cfg_data[KC_W-1:0];
        default: begin
          mode_r <= mode_r;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath: clamp, walk, divide, blend
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        q_r    <= in_data.query_time;
        last_r <= AW'(n_ext - EXT_W'(1));
        i_r    <= AW'(1);
      end
      ST_T0: begin
        // Raise to the first key time and remember it as the walk's previous key
        if (q_r < t_rdata) begin
          q_r <= t_rdata;
        end
        prev_r <= t_rdata;
      end
      ST_T1: begin
        // Lower to the last key time
        if (q_r > t_rdata) begin
          q_r <= t_rdata;
        end
      end
      ST_SEARCH: begin
        if (search_hit) begin
          ta_r <= t_rdata;
          tb_r <= prev_r;
          b_r  <= i_r - AW'(1);
        end else begin
          prev_r <= t_rdata;
          i_r    <= i_r + AW'(1);
        end
      end
      ST_SETUP: begin
        rem_r <= q_r - tb_r;
        den_r <= ta_r - tb_r;
        cnt_r <= CNT_W'(ALPHA_BITS);
        priority if (alpha_zero) begin
          alpha_r <= '0;
        end else if (alpha_one) begin
          alpha_r <= ALPHA_ONE;
        end else begin
          alpha_r <= '0;
        end
      end
      ST_DIV: begin
        // One quotient bit per cycle
        if (div_ge) begin
          rem_r <= TIME_W'(div_r2 - {1'b0, den_r});
        end else begin
          rem_r <= div_r2[TIME_W-1:0];
        end
        alpha_r <= {alpha_r[ALW-2:0], div_ge};
        cnt_r   <= cnt_r - CNT_W'(1);
      end
      ST_LOAD0: begin
        v0_r <= v_rdata;
      end
      ST_LOAD1: begin
        v1_r   <= v_rdata;
        comp_r <= 2'd0;
        // Step mode picks one whole key
        if (alpha_r >= ALPHA_HALF) begin
          res_x_r <= v_rdata[3*VAL_W-1:2*VAL_W];
          res_y_r <= v_rdata[2*VAL_W-1:VAL_W];
          res_z_r <= v_rdata[VAL_W-1:0];
        end else begin
          res_x_r <= v0_r[3*VAL_W-1:2*VAL_W];
          res_y_r <= v0_r[2*VAL_W-1:VAL_W];
          res_z_r <= v0_r[VAL_W-1:0];
        end
      end
      ST_MUL: begin
        prod_r <= mul_a * mul_b;
      end
      ST_ADD: begin
        unique case (comp_r)
          2'd0:    res_x_r <= blend_res;
          2'd1:    res_y_r <= blend_res;
          default: res_z_r <= blend_res;
        endcase
        comp_r <= comp_r + 2'd1;
      end
      ST_DONE: begin
        if (out_free) begin
          out_r.out_x         <= res_x_r;
          out_r.out_y         <= res_y_r;
          out_r.out_z         <= res_z_r;
          out_r.segment_start <= SEG_W'(b_r);
        end
      end
      default: begin
        comp_r <= comp_r;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/core/kfi_ram.sv -----
// Generic simple dual-port RAM with registered read.
module kfi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry into the output register
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for keyframe_interpolator: key table loads, step and linear samples.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kfi_pkg::*;

  localparam int              MAX_KEYS    = MAX_KEYS_DEF;
  localparam int              ALPHA_BITS  = ALPHA_BITS_DEF;
  localparam logic [63:0]     ALPHA_ONE   = 64'd1 << ALPHA_BITS;
  localparam int              ITEM_TARGET = 1600;
  // Longest sample is a full table walk plus the divide and the blends; leave margin
  localparam int              QUIET_CYCLES = 200;
  localparam int              REPORT_LIMIT = 40;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  kfi_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  kfi_out_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Stimulus and scoreboard state
  kfi_in_t  pending_items [$];
  kfi_out_t expected_samples [$];
  int       queued_count = 0;
  int       accepted_count = 0;
  int       error_count = 0;
  int       in_idle_pct = 0;
  int       out_idle_pct = 0;
  int       in_gap = 0;
  int       out_hold = 0;
  kfi_out_t want_res;

  // Shadow copy of the block's key table and registers
  logic [TIME_W-1:0] key_time_mem [MAX_KEYS];
  logic [VAL_W-1:0]  key_x_mem [MAX_KEYS];
  logic [VAL_W-1:0]  key_y_mem [MAX_KEYS];
  logic [VAL_W-1:0]  key_z_mem [MAX_KEYS];
  logic              interp_mode_q = INTERP_MODE_RST;
  logic [KC_W-1:0]   key_count_q = KEY_COUNT_RST;

  keyframe_interpolator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial forever #5 clk = ~clk;

  // a + floor((b - a) * alpha / 2^ALPHA_BITS), wrapped to 32 bits
  function automatic logic [VAL_W-1:0] blend_value(logic [VAL_W-1:0] va, logic [VAL_W-1:0] vb,
                                                   logic [63:0] w);
    logic signed [63:0] sa, sb, prod, sum;
    sa   = $signed({{32{va[31]}}, va});
    sb   = $signed({{32{vb[31]}}, vb});
    prod = (sb - sa) * $signed(w);
    sum  = sa + (prod >>> ALPHA_BITS);
    return sum[VAL_W-1:0];
  endfunction

  // Clamp the query, find the segment, compute alpha and pick or blend the keys
  function automatic kfi_out_t sample_keyframes(logic [TIME_W-1:0] query);
    int unsigned       n_used, lo, hi, idx;
    bit                found;
    logic [TIME_W-1:0] qc, t_lo, t_hi;
    logic [63:0]       weight;
    kfi_out_t          res;
    n_used = key_count_q;
    if (n_used < 2) n_used = 2;
    if (n_used > MAX_KEYS) n_used = MAX_KEYS;
    qc = query;
    if (qc < key_time_mem[0]) qc = key_time_mem[0];
    if (qc > key_time_mem[n_used-1]) qc = key_time_mem[n_used-1];
    found = 1'b0;
    lo = n_used - 2;
    for (idx = 1; idx < n_used; idx++) begin
      if (!found && key_time_mem[idx] >= qc) begin
        lo = idx - 1;
        found = 1'b1;
      end
    end
    hi = lo + 1;
    t_lo = key_time_mem[lo];
    t_hi = key_time_mem[hi];
    if (t_hi <= t_lo || qc <= t_lo) weight = '0;
    else if (qc >= t_hi) weight = ALPHA_ONE;
    else weight = ({32'd0, qc - t_lo} << ALPHA_BITS) / {32'd0, t_hi - t_lo};
    if (interp_mode_q == MODE_STEP) begin
      idx = (weight >= (ALPHA_ONE >> 1)) ? hi : lo;
      res.out_x = key_x_mem[idx];
      res.out_y = key_y_mem[idx];
      res.out_z = key_z_mem[idx];
    end else begin
      res.out_x = blend_value(key_x_mem[lo], key_x_mem[hi], weight);
      res.out_y = blend_value(key_y_mem[lo], key_y_mem[hi], weight);
      res.out_z = blend_value(key_z_mem[lo], key_z_mem[hi], weight);
    end
    res.segment_start = lo[SEG_W-1:0];
    return res;
  endfunction

  task automatic report_error(string msg);
    error_count++;
    // Keep the log short when everything goes wrong
    if (error_count <= REPORT_LIMIT) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // Driver: track register writes, predict accepted transactions, present the next item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
      interp_mode_q = INTERP_MODE_RST;
      key_count_q = KEY_COUNT_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_INTERP_MODE: interp_mode_q = cfg_data[0];
          CFG_KEY_COUNT:   key_count_q = cfg_data[KC_W-1:0];
        endcase
      end
      if (in_valid && in_ready) begin
        accepted_count++;
        if (in_data.action == ACT_WRITE) begin
          key_time_mem[in_data.key_index] = in_data.key_time;
          key_x_mem[in_data.key_index] = in_data.key_x;
          key_y_mem[in_data.key_index] = in_data.key_y;
          key_z_mem[in_data.key_index] = in_data.key_z;
        end else begin
          expected_samples.push_back(sample_keyframes(in_data.query_time));
        end
      end
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0 && $urandom_range(99) < in_idle_pct) begin
          in_gap <= $urandom_range(0, 17);
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transaction with the oldest prediction, stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_hold <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          report_error("result with no sample outstanding");
        end else begin
          want_res = expected_samples.pop_front();
          if (out_data.out_x !== want_res.out_x)
            report_error($sformatf("out_x got %h want %h", out_data.out_x, want_res.out_x));
          if (out_data.out_y !== want_res.out_y)
            report_error($sformatf("out_y got %h want %h", out_data.out_y, want_res.out_y));
          if (out_data.out_z !== want_res.out_z)
            report_error($sformatf("out_z got %h want %h", out_data.out_z, want_res.out_z));
          if (out_data.segment_start !== want_res.segment_start)
            report_error($sformatf("segment_start got %0d want %0d",
                                   out_data.segment_start, want_res.segment_start));
        end
      end
      if (out_hold != 0) begin
        out_hold <= out_hold - 1;
        out_ready <= 1'b0;
      end else if ($urandom_range(99) < out_idle_pct) begin
        out_hold <= $urandom_range(0, 17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic queue_key(int slot, logic [TIME_W-1:0] t, logic [VAL_W-1:0] x,
                           logic [VAL_W-1:0] y, logic [VAL_W-1:0] z);
    kfi_in_t item;
    item.action     = ACT_WRITE;
    item.key_index  = KI_W'(slot);
    item.key_time   = t;
    item.key_x      = x;
    item.key_y      = y;
    item.key_z      = z;
    item.query_time = $urandom;
    pending_items.push_back(item);
    queued_count++;
  endtask

  task automatic queue_sample(logic [TIME_W-1:0] q);
    kfi_in_t item;
    item.action     = ACT_SAMPLE;
    item.key_index  = KI_W'($urandom_range(0, MAX_KEYS - 1));
    item.key_time   = $urandom;
    item.key_x      = $urandom;
    item.key_y      = $urandom;
    item.key_z      = $urandom;
    item.query_time = q;
    pending_items.push_back(item);
    queued_count++;
  endtask

  // Hold until every item is accepted and every result is back, then let the block drain
  task automatic wait_quiet();
    while (accepted_count != queued_count || expected_samples.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [VAL_W-1:0] rand_value();
    if ($urandom_range(0, 1)) return $urandom;
    return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
  endfunction

  initial begin
    int                n_used, k, style;
    logic [KC_W-1:0]   cnt;
    logic [63:0]       acc;
    logic [TIME_W-1:0] q;
    logic [TIME_W-1:0] phase_times [MAX_KEYS];

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Fill every slot so no sample ever reads an unwritten key
    in_idle_pct = 15;
    out_idle_pct = 15;
    for (k = 0; k < MAX_KEYS; k++) queue_key(k, k * 1000, $urandom, $urandom, $urandom);

    // Reset settings: linear over two keys, extreme values and the clamp at the upper end
    queue_key(0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
    queue_key(1, 1000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_sample(0);
    queue_sample(1);
    queue_sample(500);
    queue_sample(1000);
    queue_sample(32'hFFFF_FFFF);

    // Step mode around alpha of one half
    wait_quiet();
    write_reg(CFG_INTERP_MODE, CFG_DATA_W'(MODE_STEP));
    queue_sample(499);
    queue_sample(500);
    queue_sample(1000);

    // Count above the table size saturates to all keys
    wait_quiet();
    write_reg(CFG_KEY_COUNT, CFG_DATA_W'(127));
    write_reg(CFG_INTERP_MODE, CFG_DATA_W'(MODE_LINEAR));
    queue_sample(31500);
    queue_sample(62999);
    queue_sample(63000);

    // Count below two, zero-length segment, then last key before first
    wait_quiet();
    write_reg(CFG_KEY_COUNT, CFG_DATA_W'(1));
    queue_key(1, 0, rand_value(), rand_value(), rand_value());
    queue_sample(7);
    queue_key(0, 5000, rand_value(), rand_value(), rand_value());
    queue_key(1, 100, rand_value(), rand_value(), rand_value());
    queue_sample(3000);
    queue_sample(0);

    wait_quiet();
    write_reg(CFG_KEY_COUNT, CFG_DATA_W'(0));
    queue_key(0, 0, 32'h7FFF_FFFF, 32'h8000_0000, rand_value());
    queue_key(1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, rand_value());
    queue_sample(32'h8000_0000);
    queue_sample(32'hFFFF_FFFE);

    // Reversed segment at the start of the table
    wait_quiet();
    write_reg(CFG_KEY_COUNT, CFG_DATA_W'(3));
    queue_key(0, 900, rand_value(), rand_value(), rand_value());
    queue_key(1, 200, rand_value(), rand_value(), rand_value());
    queue_key(2, 100, rand_value(), rand_value(), rand_value());
    queue_sample(50);

    // Random phases: new settings, rebuilt table, then a batch of samples
    while (queued_count < ITEM_TARGET) begin
      wait_quiet();
      if (queued_count >= ITEM_TARGET - 200) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0: in_idle_pct = 0;
          1: in_idle_pct = 5;
          2: in_idle_pct = 20;
          default: in_idle_pct = 40;
        endcase
        case ($urandom_range(0, 3))
          0: out_idle_pct = 0;
          1: out_idle_pct = 5;
          2: out_idle_pct = 20;
          default: out_idle_pct = 40;
        endcase
      end
      write_reg(CFG_INTERP_MODE,
                CFG_DATA_W'($urandom_range(0, 1) ? MODE_LINEAR : MODE_STEP));
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 5))
            0: cnt = KC_W'(0);
            1: cnt = KC_W'(1);
            2: cnt = KC_W'(2);
            3: cnt = KC_W'(64);
            4: cnt = KC_W'(65);
            default: cnt = KC_W'(127);
          endcase
        end
        1, 2, 3: cnt = KC_W'($urandom_range(2, 64));
        default: cnt = KC_W'($urandom_range(2, 12));
      endcase
      write_reg(CFG_KEY_COUNT, cnt);
      n_used = (cnt < 2) ? 2 : (cnt > MAX_KEYS) ? MAX_KEYS : cnt;

      // Mostly nondecreasing times; some shuffled, flat or descending tables
      style = $urandom_range(0, 9);
      acc = '0;
      for (k = 0; k < n_used; k++) begin
        case (style)
          7: phase_times[k] = $urandom;
          8: phase_times[k] = (k == 0) ? $urandom : phase_times[0];
          9: phase_times[k] = (k == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 1000)
                                       : phase_times[k-1] - $urandom_range(0, 5000);
          default: begin
            if (k == 0) begin
              case ($urandom_range(0, 2))
                0: acc = '0;
                1: acc = 64'($urandom_range(0, 1000));
                default: acc = 64'($urandom >> 1);
              endcase
            end else begin
              case ($urandom_range(0, 9))
                0: acc = acc;
                1, 2, 3, 4, 5: acc = acc + 64'($urandom_range(1, 64));
                6, 7, 8: acc = acc + 64'($urandom_range(1, 100000));
                default: acc = acc + 64'($urandom >> $urandom_range(0, 8));
              endcase
              if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
            end
            phase_times[k] = acc[TIME_W-1:0];
          end
        endcase
        queue_key(k, phase_times[k], rand_value(), rand_value(), rand_value());
      end
      // Touch slots outside the used range now and then
      if (n_used < MAX_KEYS && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4))
          queue_key($urandom_range(n_used, MAX_KEYS - 1), $urandom, $urandom, $urandom, $urandom);
      end

      repeat ($urandom_range(20, 60)) begin
        k = $urandom_range(0, n_used - 1);
        case ($urandom_range(0, 9))
          0: q = '0;
          1: q = '1;
          2, 3: q = phase_times[k];
          4: q = phase_times[k] + 1;
          5: q = phase_times[k] - 1;
          6, 7, 8: q = (k + 1 < n_used)
                     ? phase_times[k] + $urandom_range(0, phase_times[k+1] - phase_times[k])
                     : phase_times[k];
          default: q = $urandom;
        endcase
        queue_sample(q);
      end
    end

    wait_quiet();
    if (error_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // Watchdog, several times the slowest legal run
  initial begin
    #15_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
